[src/vkf_pkg.sv]
// Shared types and codes for the velocity Kalman fusion block.
// Used by vkf_ctrl, vkf_datapath and the velocity_kalman_fusion top level.
`default_nettype none
package vkf_pkg;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 3;
   localparam int MUL_W    = 34;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int NUM_CORR = 5;

   localparam logic [INDEX_W-1:0] REG_STEP_TIME   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_ACCEL_NOISE = 3'd1;
   localparam logic [INDEX_W-1:0] REG_ODOM_NOISE  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CAM_NOISE   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_INITIAL_VAR = 3'd4;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_DT2_MUL   = 5'd2;
   localparam logic [OP_W-1:0] OP_DT2_RND   = 5'd3;
   localparam logic [OP_W-1:0] OP_Q_MUL     = 5'd4;
   localparam logic [OP_W-1:0] OP_Q_RND     = 5'd5;
   localparam logic [OP_W-1:0] OP_ACC_MUL   = 5'd6;
   localparam logic [OP_W-1:0] OP_PRED_UPD  = 5'd7;
   localparam logic [OP_W-1:0] OP_CORR_INIT = 5'd8;
   localparam logic [OP_W-1:0] OP_DIV_START = 5'd9;
   localparam logic [OP_W-1:0] OP_K_LOAD    = 5'd10;
   localparam logic [OP_W-1:0] OP_KDIFF_MUL = 5'd11;
   localparam logic [OP_W-1:0] OP_V_UPD     = 5'd12;
   localparam logic [OP_W-1:0] OP_A2        = 5'd13;
   localparam logic [OP_W-1:0] OP_K2        = 5'd14;
   localparam logic [OP_W-1:0] OP_T1        = 5'd15;
   localparam logic [OP_W-1:0] OP_P_UPD     = 5'd16;
   localparam logic [OP_W-1:0] OP_OUT       = 5'd17;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      axis;
      logic            use_cam;
   } vkf_cmd_type;

   typedef struct packed {
      logic div_done;
      logic den_zero;
   } vkf_status_type;
endpackage
`default_nettype wire

[src/velocity_kalman_fusion.sv]
// Top level of the three-axis velocity Kalman fusion block.
// Depends on vkf_pkg, vkf_ctrl, vkf_datapath (with vkf_div).
// One req beat is one filter step: predict x, y and yaw with the IMU
// accelerations, correct x and yaw with odometry, then all three axes with the
// camera; one rsp beat returns the three velocities and variances.
// Values are signed/unsigned fixed point with FRAC_BITS fraction bits
// (Q16.16 by default), saturated to 32 bits. The step length is set by the
// gain divider, which retires one quotient bit per cycle for each of the five
// corrections, and by the single shared multiplier. The block takes a new
// beat only when idle; a finished result waits in the output register while
// the next step is accepted. Writing initial_var also reloads all three
// variances. Configure only while idle.
`default_nettype none
module velocity_kalman_fusion #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_y,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_yaw,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_odom_vel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_odom_vel_yaw,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_y,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_yaw,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [vkf_pkg::DATA_W-1:0]      rsp_est_vel_x,
   output logic signed [vkf_pkg::DATA_W-1:0]      rsp_est_vel_y,
   output logic signed [vkf_pkg::DATA_W-1:0]      rsp_est_vel_yaw,
   output logic [vkf_pkg::DATA_W-1:0]             rsp_var_x,
   output logic [vkf_pkg::DATA_W-1:0]             rsp_var_y,
   output logic [vkf_pkg::DATA_W-1:0]             rsp_var_yaw,
   input  wire logic                              csr_we,
   input  wire logic [vkf_pkg::INDEX_W-1:0]       csr_index,
   input  wire logic [vkf_pkg::DATA_W-1:0]        csr_wdata
);
   import vkf_pkg::*;

   vkf_cmd_type    cmd;
   vkf_status_type status;

   vkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   vkf_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_yaw    (req_accel_yaw),
      .req_odom_vel_x   (req_odom_vel_x),
      .req_odom_vel_yaw (req_odom_vel_yaw),
      .req_cam_vel_x    (req_cam_vel_x),
      .req_cam_vel_y    (req_cam_vel_y),
      .req_cam_vel_yaw  (req_cam_vel_yaw),
      .rsp_est_vel_x    (rsp_est_vel_x),
      .rsp_est_vel_y    (rsp_est_vel_y),
      .rsp_est_vel_yaw  (rsp_est_vel_yaw),
      .rsp_var_x        (rsp_var_x),
      .rsp_var_y        (rsp_var_y),
      .rsp_var_yaw      (rsp_var_yaw)
   );
endmodule
`default_nettype wire

[src/vkf_div.sv]
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Requires num < den * 2^Q_W. No package dependency.
`default_nettype none
module vkf_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 33,
   parameter int Q_W   = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [Q_W-1:0]        quot
);
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W+1:0] trial;

   always_comb begin
      trial   = {1'b0, rem_ff, q_ff[Q_W-1]} - {2'b00, den};
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = DEN_W'(num[NUM_W-1:Q_W]);
         q_in    = num[Q_W-1:0];
         cnt_in  = CNT_W'(Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DEN_W+1]) begin
            rem_in = {rem_ff[DEN_W-2:0], q_ff[Q_W-1]};
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         q_in   = {q_ff[Q_W-2:0], ~trial[DEN_W+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[src/vkf_datapath.sv]
// Datapath: filter state, config registers, shared multiplier, gain divider.
// Depends on vkf_pkg and vkf_div; driven by commands from vkf_ctrl.
`default_nettype none
module vkf_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vkf_pkg::vkf_cmd_type          cmd,
   output vkf_pkg::vkf_status_type            status,
   input  wire logic                          csr_we,
   input  wire logic [vkf_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [vkf_pkg::DATA_W-1:0]    csr_wdata,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_y,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_accel_yaw,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_odom_vel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_odom_vel_yaw,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_x,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_y,
   input  wire logic signed [vkf_pkg::DATA_W-1:0] req_cam_vel_yaw,
   output logic signed [vkf_pkg::DATA_W-1:0]  rsp_est_vel_x,
   output logic signed [vkf_pkg::DATA_W-1:0]  rsp_est_vel_y,
   output logic signed [vkf_pkg::DATA_W-1:0]  rsp_est_vel_yaw,
   output logic [vkf_pkg::DATA_W-1:0]         rsp_var_x,
   output logic [vkf_pkg::DATA_W-1:0]         rsp_var_y,
   output logic [vkf_pkg::DATA_W-1:0]         rsp_var_yaw
);
   import vkf_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int K_W   = F + 1;
   localparam int DEN_W = DATA_W + 1;
   localparam int NUM_W = DATA_W + 1 + F;
   localparam int RND_W = PROD_W - F;
   localparam int SUM_W = RND_W + 1;

   localparam longint unsigned ONE_L   = 64'd1 << F;
   localparam longint unsigned MAX_U   = 64'hFFFF_FFFF;
   localparam longint unsigned R400_L  = 64'd400 << F;
   localparam longint unsigned V500_L  = 64'd500 << F;
   localparam logic [DATA_W-1:0] STEP_RST = DATA_W'(ONE_L >> 2);
   localparam logic [DATA_W-1:0] Q_RST    = DATA_W'((ONE_L + 64'd50) / 64'd100);
   localparam logic [DATA_W-1:0] R_RST    = (R400_L > MAX_U) ? '1 : DATA_W'(R400_L);
   localparam logic [DATA_W-1:0] P_RST    = (V500_L > MAX_U) ? '1 : DATA_W'(V500_L);
   localparam logic [K_W-1:0]    ONE_K    = {1'b1, {F{1'b0}}};
   localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(64'd1 << (F - 1));
   localparam logic signed [SUM_W-1:0]  S_MAX  = SUM_W'(64'h7FFF_FFFF);
   localparam logic signed [SUM_W-1:0]  S_MIN  = -S_MAX - 1;
   localparam logic signed [SUM_W-1:0]  U_MAX  = SUM_W'(MAX_U);

   function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] s;
      s = (x + HALF_P) >>> F;
      return s[RND_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sat_s(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] y;
      y = x;
      if (x > S_MAX) y = S_MAX;
      if (x < S_MIN) y = S_MIN;
      return y[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sat_u(input logic signed [SUM_W-1:0] x);
      logic [DATA_W-1:0] y;
      y = x[DATA_W-1:0];
      if (x > U_MAX) y = '1;
      return y;
   endfunction

   // configuration
   logic [DATA_W-1:0] step_ff, qvar_ff, odom_r_ff, cam_r_ff;
   // filter state
   logic signed [DATA_W-1:0] v_ff [3];
   logic signed [DATA_W-1:0] v_in [3];
   logic [DATA_W-1:0]        p_ff [3];
   logic [DATA_W-1:0]        p_in [3];
   // latched step inputs
   logic signed [DATA_W-1:0] acc_ff [3];
   logic signed [DATA_W-1:0] cam_ff [3];
   logic signed [DATA_W-1:0] odom_x_ff, odom_yaw_ff;
   // working registers
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [DATA_W-1:0]        dt2_ff, qq_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [DATA_W:0]   diff_ff;
   logic [K_W-1:0]           k_ff, a2_ff, k2_ff;
   logic [DATA_W:0]          t1_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     mul_en;
   logic signed [RND_W-1:0]  rnd_val;
   logic signed [SUM_W-1:0]  v_sum, p_pred_sum, p_corr_sum;
   logic signed [DATA_W-1:0] v_sel, z_sel;
   logic [DATA_W-1:0]        p_sel, r_sel;
   logic [K_W-1:0]           a_val;
   logic [NUM_W-1:0]         div_num;
   logic                     div_start, div_done;
   logic [K_W-1:0]           div_quot;

   assign v_sel   = v_ff[cmd.axis];
   assign p_sel   = p_ff[cmd.axis];
   assign r_sel   = cmd.use_cam ? cam_r_ff : odom_r_ff;
   assign z_sel   = cmd.use_cam ? cam_ff[cmd.axis] :
                    ((cmd.axis == 2'd0) ? odom_x_ff : odom_yaw_ff);
   assign a_val   = ONE_K - k_ff;
   assign rnd_val = rnd(prod_ff);
   assign v_sum   = {{(SUM_W-DATA_W){v_sel[DATA_W-1]}}, v_sel} +
                    {rnd_val[RND_W-1], rnd_val};
   assign p_pred_sum = SUM_W'(p_sel) + SUM_W'(qq_ff);
   assign p_corr_sum = SUM_W'(t1_ff) + {rnd_val[RND_W-1], rnd_val};
   assign div_num    = NUM_W'({p_sel, {F{1'b0}}}) + NUM_W'(den_ff >> 1);
   assign div_start  = (cmd.op == OP_DIV_START);

   vkf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(K_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign status.div_done = div_done;
   assign status.den_zero = (den_ff == '0);

   // one shared multiplier, product always registered
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_DT2_MUL:   begin mul_a = MUL_W'(step_ff); mul_b = MUL_W'(step_ff); end
         OP_Q_MUL:     begin mul_a = MUL_W'(dt2_ff);  mul_b = MUL_W'(qvar_ff); end
         OP_ACC_MUL:   begin mul_a = MUL_W'(step_ff); mul_b = MUL_W'(acc_ff[cmd.axis]); end
         OP_KDIFF_MUL: begin mul_a = MUL_W'(k_ff);    mul_b = MUL_W'(diff_ff); end
         OP_V_UPD:     begin mul_a = MUL_W'(a_val);   mul_b = MUL_W'(a_val); end
         OP_A2:        begin mul_a = MUL_W'(k_ff);    mul_b = MUL_W'(k_ff); end
         OP_K2:        begin mul_a = MUL_W'(a2_ff);   mul_b = MUL_W'(p_sel); end
         OP_T1:        begin mul_a = MUL_W'(k2_ff);   mul_b = MUL_W'(r_sel); end
         default:      mul_en = 1'b0;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      v_in = v_ff;
      p_in = p_ff;
      case (cmd.op)
         OP_PRED_UPD: begin
            v_in[cmd.axis] = sat_s(v_sum);
            p_in[cmd.axis] = sat_u(p_pred_sum);
         end
         OP_V_UPD: v_in[cmd.axis] = sat_s(v_sum);
         OP_P_UPD: p_in[cmd.axis] = sat_u(p_corr_sum);
         default: ;
      endcase
      // initial_var write reloads all variances
      if (csr_we && csr_index == REG_INITIAL_VAR) begin
         p_in[0] = csr_wdata;
         p_in[1] = csr_wdata;
         p_in[2] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RST;
         qvar_ff   <= Q_RST;
         odom_r_ff <= R_RST;
         cam_r_ff  <= R_RST;
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= '0;
            p_ff[i] <= P_RST;
         end
      end else begin
         v_ff <= v_in;
         p_ff <= p_in;
         if (csr_we) begin
            case (csr_index)
               REG_STEP_TIME:   step_ff   <= csr_wdata;
               REG_ACCEL_NOISE: qvar_ff   <= csr_wdata;
               REG_ODOM_NOISE:  odom_r_ff <= csr_wdata;
               REG_CAM_NOISE:   cam_r_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= prod_in;
      case (cmd.op)
         OP_LOAD: begin
            acc_ff[0]   <= req_accel_x;
            acc_ff[1]   <= req_accel_y;
            acc_ff[2]   <= req_accel_yaw;
            odom_x_ff   <= req_odom_vel_x;
            odom_yaw_ff <= req_odom_vel_yaw;
            cam_ff[0]   <= req_cam_vel_x;
            cam_ff[1]   <= req_cam_vel_y;
            cam_ff[2]   <= req_cam_vel_yaw;
         end
         OP_DT2_RND: dt2_ff <= sat_u({rnd_val[RND_W-1], rnd_val});
         OP_Q_RND:   qq_ff  <= sat_u({rnd_val[RND_W-1], rnd_val});
         OP_CORR_INIT: begin
            den_ff  <= DEN_W'(p_sel) + DEN_W'(r_sel);
            diff_ff <= {z_sel[DATA_W-1], z_sel} - {v_sel[DATA_W-1], v_sel};
         end
         OP_K_LOAD:  k_ff  <= (div_quot > ONE_K) ? ONE_K : div_quot;
         OP_A2:      a2_ff <= rnd_val[K_W-1:0];
         OP_K2:      k2_ff <= rnd_val[K_W-1:0];
         OP_T1:      t1_ff <= rnd_val[DATA_W:0];
         OP_OUT: begin
            rsp_est_vel_x   <= v_ff[0];
            rsp_est_vel_y   <= v_ff[1];
            rsp_est_vel_yaw <= v_ff[2];
            rsp_var_x       <= p_ff[0];
            rsp_var_y       <= p_ff[1];
            rsp_var_yaw     <= p_ff[2];
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

[src/vkf_ctrl.sv]
// Sequencer for one filter step: predict three axes, then five corrections.
// Depends on vkf_pkg; issues commands to vkf_datapath.
`default_nettype none
module vkf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output vkf_pkg::vkf_cmd_type         cmd,
   input  wire vkf_pkg::vkf_status_type status
);
   import vkf_pkg::*;

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_DT2_MUL    = 5'd1;
   localparam logic [4:0] S_DT2_RND    = 5'd2;
   localparam logic [4:0] S_Q_MUL      = 5'd3;
   localparam logic [4:0] S_Q_RND      = 5'd4;
   localparam logic [4:0] S_ACC_MUL    = 5'd5;
   localparam logic [4:0] S_PRED_UPD   = 5'd6;
   localparam logic [4:0] S_CORR_INIT  = 5'd7;
   localparam logic [4:0] S_DIV_START  = 5'd8;
   localparam logic [4:0] S_DIV_WAIT   = 5'd9;
   localparam logic [4:0] S_K_LOAD     = 5'd10;
   localparam logic [4:0] S_KDIFF_MUL  = 5'd11;
   localparam logic [4:0] S_V_UPD      = 5'd12;
   localparam logic [4:0] S_A2         = 5'd13;
   localparam logic [4:0] S_K2         = 5'd14;
   localparam logic [4:0] S_T1         = 5'd15;
   localparam logic [4:0] S_P_UPD      = 5'd16;
   localparam logic [4:0] S_OUT        = 5'd17;

   localparam logic [2:0] LAST_CORR = 3'(NUM_CORR - 1);

   logic [4:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] corr_ff, corr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] corr_axis;
   logic       corr_cam;
   logic       predicting;

   // correction order: odometry x, odometry yaw, camera x, y, yaw
   always_comb begin
      case (corr_ff)
         3'd1:    corr_axis = 2'd2;
         3'd3:    corr_axis = 2'd1;
         3'd4:    corr_axis = 2'd2;
         default: corr_axis = 2'd0;
      endcase
      corr_cam = (corr_ff >= 3'd2);
   end

   assign predicting = (state_ff == S_ACC_MUL) || (state_ff == S_PRED_UPD);

   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      corr_in     = corr_ff;
      cmd.op      = OP_NOP;
      cmd.axis    = predicting ? axis_ff : corr_axis;
      cmd.use_cam = corr_cam;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               axis_in  = 2'd0;
               state_in = S_DT2_MUL;
            end
         end
         S_DT2_MUL: begin cmd.op = OP_DT2_MUL; state_in = S_DT2_RND; end
         S_DT2_RND: begin cmd.op = OP_DT2_RND; state_in = S_Q_MUL; end
         S_Q_MUL:   begin cmd.op = OP_Q_MUL;   state_in = S_Q_RND; end
         S_Q_RND:   begin cmd.op = OP_Q_RND;   state_in = S_ACC_MUL; end
         S_ACC_MUL: begin cmd.op = OP_ACC_MUL; state_in = S_PRED_UPD; end
         S_PRED_UPD: begin
            cmd.op = OP_PRED_UPD;
            if (axis_ff == 2'd2) begin
               corr_in  = 3'd0;
               state_in = S_CORR_INIT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_ACC_MUL;
            end
         end
         S_CORR_INIT: begin cmd.op = OP_CORR_INIT; state_in = S_DIV_START; end
         S_DIV_START: begin
            // zero denominator leaves the axis untouched
            if (status.den_zero) begin
               if (corr_ff == LAST_CORR) begin
                  state_in = S_OUT;
               end else begin
                  corr_in  = corr_ff + 3'd1;
                  state_in = S_CORR_INIT;
               end
            end else begin
               cmd.op   = OP_DIV_START;
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) state_in = S_K_LOAD;
         end
         S_K_LOAD:    begin cmd.op = OP_K_LOAD;    state_in = S_KDIFF_MUL; end
         S_KDIFF_MUL: begin cmd.op = OP_KDIFF_MUL; state_in = S_V_UPD; end
         S_V_UPD:     begin cmd.op = OP_V_UPD;     state_in = S_A2; end
         S_A2:        begin cmd.op = OP_A2;        state_in = S_K2; end
         S_K2:        begin cmd.op = OP_K2;        state_in = S_T1; end
         S_T1:        begin cmd.op = OP_T1;        state_in = S_P_UPD; end
         S_P_UPD: begin
            cmd.op = OP_P_UPD;
            if (corr_ff == LAST_CORR) begin
               state_in = S_OUT;
            end else begin
               corr_in  = corr_ff + 3'd1;
               state_in = S_CORR_INIT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         corr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         corr_ff      <= corr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DT2_MUL))
      else $error("accepted beat did not start a step");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |=> rsp_valid)
      else $error("result load did not raise rsp_valid");
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      corr_ff <= LAST_CORR)
      else $error("correction index out of range");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside its wait state");
endmodule
`default_nettype wire

[tb/tb_velocity_kalman_fusion.sv]
// Self-checking testbench for velocity_kalman_fusion: a directed and random filter-step
// stream checked against an in-bench model of the three scalar Kalman filters.
// Depends on vkf_pkg and the velocity_kalman_fusion RTL only.
`timescale 1ns / 100ps
`default_nettype none
module tb_velocity_kalman_fusion;
   import vkf_pkg::*;

   localparam int FRAC = 16;
   localparam longint unsigned ONE_Q = 64'd1 << FRAC;
   localparam longint unsigned HALF_Q = 64'd1 << (FRAC - 1);
   localparam longint unsigned MAX_U32 = 64'hFFFF_FFFF;
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      logic signed [31:0] accel_x, accel_y, accel_yaw;
      logic signed [31:0] odom_x, odom_yaw;
      logic signed [31:0] cam_x, cam_y, cam_yaw;
   } sensor_step_type;

   typedef struct packed {
      logic [31:0] vel_x, vel_y, vel_yaw, var_x, var_y, var_yaw;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sensor_step_type req_beat = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   estimate_type rsp_beat;
   logic csr_we = 1'b0;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   always #5 clock = ~clock;

   velocity_kalman_fusion dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_accel_x(req_beat.accel_x), .req_accel_y(req_beat.accel_y),
      .req_accel_yaw(req_beat.accel_yaw), .req_odom_vel_x(req_beat.odom_x),
      .req_odom_vel_yaw(req_beat.odom_yaw), .req_cam_vel_x(req_beat.cam_x),
      .req_cam_vel_y(req_beat.cam_y), .req_cam_vel_yaw(req_beat.cam_yaw),
      .rsp_valid, .rsp_stall,
      .rsp_est_vel_x(rsp_beat.vel_x), .rsp_est_vel_y(rsp_beat.vel_y),
      .rsp_est_vel_yaw(rsp_beat.vel_yaw), .rsp_var_x(rsp_beat.var_x),
      .rsp_var_y(rsp_beat.var_y), .rsp_var_yaw(rsp_beat.var_yaw),
      .csr_we, .csr_index, .csr_wdata
   );

   // filter model state and registers
   longint unsigned dt_q, accel_q, odom_r, cam_r, init_p;
   longint vel_est[3];
   longint unsigned var_est[3];

   sensor_step_type pending_steps[$];
   estimate_type expected_estimates[$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int steps_sent = 0;
   int estimates_checked = 0;
   int mismatches = 0;
   int cycles = 0;
   int reg_writes = 0;
   logic req_fire = 1'b0;
   string field_names[6] = '{"est_vel_x", "est_vel_y", "est_vel_yaw",
                             "var_x", "var_y", "var_yaw"};

   function automatic longint unsigned round_u(longint unsigned x);
      return (x + HALF_Q) >> FRAC;
   endfunction

   function automatic longint round_s(longint x);
      return (x + longint'(HALF_Q)) >>> FRAC;
   endfunction

   function automatic longint unsigned clamp_u(longint unsigned x);
      return (x > MAX_U32) ? MAX_U32 : x;
   endfunction

   function automatic longint clamp_s(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic void predict_axis(int axis, longint accel);
      longint dv;
      longint unsigned dt2, qq;
      dv = round_s(longint'(dt_q) * accel);
      dt2 = clamp_u(round_u(dt_q * dt_q));
      qq = clamp_u(round_u(dt2 * accel_q));
      vel_est[axis] = clamp_s(vel_est[axis] + dv);
      var_est[axis] = clamp_u(var_est[axis] + qq);
   endfunction

   function automatic void correct_axis(int axis, longint z, longint unsigned r);
      longint unsigned p, den, k, a2, k2;
      longint diff;
      p = var_est[axis];
      den = p + r;
      if (den == 0) return;
      k = ((p << FRAC) + den / 2) / den;
      if (k > ONE_Q) k = ONE_Q;
      diff = z - vel_est[axis];
      vel_est[axis] = clamp_s(vel_est[axis] + round_s(longint'(k) * diff));
      a2 = round_u((ONE_Q - k) * (ONE_Q - k));
      k2 = round_u(k * k);
      var_est[axis] = clamp_u(round_u(a2 * p) + round_u(k2 * r));
   endfunction

   function automatic estimate_type fuse_step(sensor_step_type s);
      estimate_type e;
      predict_axis(0, longint'(s.accel_x));
      predict_axis(1, longint'(s.accel_y));
      predict_axis(2, longint'(s.accel_yaw));
      correct_axis(0, longint'(s.odom_x), odom_r);
      correct_axis(2, longint'(s.odom_yaw), odom_r);
      correct_axis(0, longint'(s.cam_x), cam_r);
      correct_axis(1, longint'(s.cam_y), cam_r);
      correct_axis(2, longint'(s.cam_yaw), cam_r);
      e.vel_x = vel_est[0][31:0];
      e.vel_y = vel_est[1][31:0];
      e.vel_yaw = vel_est[2][31:0];
      e.var_x = var_est[0][31:0];
      e.var_y = var_est[1][31:0];
      e.var_yaw = var_est[2][31:0];
      return e;
   endfunction

   // sender: new beat only when the line is free or the last beat was taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_beat <= pending_steps.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // accept side: model the accepted step, check the returned estimate
   always @(posedge clock) begin
      estimate_type exp_e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d estimates outstanding", $time, expected_estimates.size());
         $display("tb_velocity_kalman_fusion NOT OK");
         $finish;
      end
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         expected_estimates.insert(expected_estimates.size(), fuse_step(req_beat));
         steps_sent++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_estimates.size() == 0) begin
            $display("%0t: unexpected estimate beat %h", $time, rsp_beat);
            mismatches++;
         end else begin
            exp_e = expected_estimates.pop_front();
            estimates_checked++;
            for (int i = 0; i < 6; i++)
               if (rsp_beat[(5-i)*32 +: 32] !== exp_e[(5-i)*32 +: 32]) begin
                  $display("%0t: %s expected %h actual %h", $time, field_names[i],
                           exp_e[(5-i)*32 +: 32], rsp_beat[(5-i)*32 +: 32]);
                  mismatches++;
               end
         end
      end
   end

   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      reg_writes++;
      case (idx)
         REG_STEP_TIME: dt_q = val;
         REG_ACCEL_NOISE: accel_q = val;
         REG_ODOM_NOISE: odom_r = val;
         REG_CAM_NOISE: cam_r = val;
         REG_INITIAL_VAR: begin
            init_p = val;
            for (int i = 0; i < 3; i++) var_est[i] = val;
         end
         default: ;
      endcase
   endtask

   // wait until every queued step has been sent and its estimate checked
   task automatic drain();
      while (pending_steps.size() > 0 || req_valid || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] sensor_value(bit wide);
      if (wide) return $urandom;
      return 32'($urandom_range(32'd13107200)) - 32'd6553600;
   endfunction

   task automatic queue_random(int count);
      sensor_step_type s;
      bit wide;
      for (int n = 0; n < count; n++) begin
         wide = ($urandom_range(99) < 25);
         s.accel_x = sensor_value(wide);
         s.accel_y = sensor_value(wide);
         s.accel_yaw = sensor_value(wide);
         s.odom_x = sensor_value(wide);
         s.odom_yaw = sensor_value(wide);
         s.cam_x = sensor_value(wide);
         s.cam_y = sensor_value(wide);
         s.cam_yaw = sensor_value(wide);
         pending_steps.insert(pending_steps.size(), s);
      end
   endtask

   function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] dflt);
      case ($urandom_range(3))
         0: return lo;
         1: return hi;
         2: return dflt;
         default: return ($urandom == 0) ? lo : $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] pattern[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                  32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF};
      sensor_step_type s;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      dt_q = 64'd16384;
      accel_q = 64'd655;
      odom_r = 64'd26214400;
      cam_r = 64'd26214400;
      init_p = 64'd32768000;
      for (int i = 0; i < 3; i++) begin
         vel_est[i] = 0;
         var_est[i] = init_p;
      end

      // directed: reset settings, field extremes and alternating patterns
      foreach (pattern[i]) begin
         s = {8{pattern[i]}};
         pending_steps.insert(pending_steps.size(), s);
         s = {pattern[i], ~pattern[i], pattern[i], ~pattern[i],
              pattern[i], ~pattern[i], pattern[i], ~pattern[i]};
         pending_steps.insert(pending_steps.size(), s);
      end
      queue_random(6);
      drain();

      // register extremes: tiny and huge noise, huge step, zero start variance
      write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
      write_reg(REG_ACCEL_NOISE, 32'hFFFF_FFFF);
      write_reg(REG_ODOM_NOISE, 32'd1);
      write_reg(REG_CAM_NOISE, 32'hFFFF_FFFF);
      write_reg(REG_INITIAL_VAR, 32'd0);
      write_reg(3'd5, $urandom);
      write_reg(3'd7, $urandom);
      foreach (pattern[i]) begin
         s = {8{pattern[i]}};
         pending_steps.insert(pending_steps.size(), s);
      end
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0; end
            2: begin send_idle_pct = 0; rsp_stall_pct = 77; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         write_reg(REG_STEP_TIME, pick(32'd1, 32'hFFFF_FFFF, 32'd16384));
         write_reg(REG_ACCEL_NOISE, pick(32'd0, 32'hFFFF_FFFF, 32'd655));
         write_reg(REG_ODOM_NOISE, pick(32'd1, 32'hFFFF_FFFF, 32'd26214400));
         write_reg(REG_CAM_NOISE, pick(32'd1, 32'hFFFF_FFFF, 32'd26214400));
         if (phase != 2) write_reg(REG_INITIAL_VAR, pick(32'd0, 32'hFFFF_FFFF, 32'd32768000));
         write_reg(INDEX_W'($urandom_range(5, 7)), $urandom);
         queue_random(40);
         drain();
         queue_random(40);
         drain();
      end

      $display("%0d filter steps sent, %0d estimates checked, %0d register writes,",
               steps_sent, estimates_checked, reg_writes);
      $display("covering register extremes and sender/receiver idle mixes");
      if (mismatches == 0 && expected_estimates.size() == 0)
         $display("tb_velocity_kalman_fusion OK");
      else
         $display("tb_velocity_kalman_fusion NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
src/vkf_pkg.sv
src/vkf_div.sv
src/vkf_datapath.sv
src/vkf_ctrl.sv
src/velocity_kalman_fusion.sv
tb/tb_velocity_kalman_fusion.sv
